/* rtl/core/assert_macros.svh */
// Assertion macros for the character LCD write sequencer.
// Define NO_ASSERTIONS to compile them out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS
`define CHK_ALWAYS(name, clk, rst, expr) \
  name: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("check failed");
`define CHK_NEXT(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("check failed");
`else
`define CHK_ALWAYS(name, clk, rst, expr)
`define CHK_NEXT(name, clk, rst, ante, cons)
`endif

`endif

/* rtl/core/clcd_pkg.sv */
// Shared types, op codes and init table for the LCD write sequencer.
// No dependencies.
`timescale 1ns / 1ps
package clcd_pkg;

  localparam int HoldW = 20;

  localparam logic [2:0] OP_CMD  = 3'd0;
  localparam logic [2:0] OP_DATA = 3'd1;
  localparam logic [2:0] OP_SLOW = 3'd2;
  localparam logic [2:0] OP_POS  = 3'd3;
  localparam logic [2:0] OP_INIT = 3'd4;

  localparam logic       REG_HOLD_SHORT = 1'b0;
  localparam logic       REG_HOLD_LONG  = 1'b1;

  localparam logic [2:0] LAST_INIT_BYTE = 3'd6;

  localparam logic [7:0] POS_LINE1 = 8'h80;
  localparam logic [1:0] LINE1_TAG = 2'b10;
  localparam logic [1:0] LINE2_TAG = 2'b11;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_RUN  = 2'b10
  } state_t;

  typedef struct packed {
    logic       rs;
    logic       slow;
    logic [7:0] code;
    logic       final_byte;
  } byte_info_t;

  typedef struct packed {
    logic       busy;
    logic [2:0] byte_idx;
  } seq_status_t;

  function automatic logic [7:0] init_byte(input logic [2:0] idx);
    logic [7:0] b;
    case (idx)
      3'd0:    b = 8'h33;
      3'd1:    b = 8'h32;
      3'd2:    b = 8'h01;
      3'd3:    b = 8'h02;
      3'd4:    b = 8'h0F;
      3'd5:    b = 8'h28;
      3'd6:    b = 8'h06;
      default: b = 8'h06;
    endcase
    return b;
  endfunction

  function automatic logic init_slow(input logic [2:0] idx);
    return (idx == 3'd2) || (idx == 3'd3);
  endfunction

endpackage

/* rtl/core/clcd_if.sv */
// Request and bus-phase channel interfaces.
// Depends on clcd_pkg.
`timescale 1ns / 1ps
interface clcd_req_if;
  logic       valid;
  logic       ready;
  logic [2:0] op;
  logic [7:0] value;
  logic [5:0] row;
  logic [1:0] column;
  modport source (output valid, op, value, row, column, input ready);
  modport sink   (input valid, op, value, row, column, output ready);
endinterface

interface clcd_phase_if import clcd_pkg::*;;
  logic             valid;
  logic             ready;
  logic             reg_select;
  logic             enable;
  logic [3:0]       nibble;
  logic [HoldW-1:0] hold_ticks;
  logic             last;
  modport source (output valid, reg_select, enable, nibble, hold_ticks, last, input ready);
  modport sink   (input valid, reg_select, enable, nibble, hold_ticks, last, output ready);
endinterface

/* rtl/core/char_lcd_nibble_write_sequencer.sv */
// Top level of the 4-bit character LCD write sequencer; hold registers.
// Depends on clcd_pkg, clcd_if, clcd_seq and assert_macros.svh.
// An accepted request sets the state to run; the first phase then enters the output register.
// Throughput: one phase per cycle while the sink is ready, 4 per byte, 28 for init;
// the next request is taken only once the last phase is loaded and the state is idle again.
// Reset (synchronous, rst high): idle, no phase pending, holds 5000 / 100000.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module char_lcd_nibble_write_sequencer import clcd_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr_en,
  input  logic             wr_index,
  input  logic [HoldW-1:0] wr_data,
  clcd_req_if.sink         req,
  clcd_phase_if.source     phase
);

  logic [HoldW-1:0] short_hold;
  logic [HoldW-1:0] long_hold;
  seq_status_t      status;

  always_ff @(posedge clk) begin
    if (rst) begin
      short_hold <= HoldW'(5000);
      long_hold  <= HoldW'(100000);
    end else if (wr_en) begin
      case (wr_index)
        REG_HOLD_SHORT: short_hold <= wr_data;
        REG_HOLD_LONG:  long_hold  <= wr_data;
        default: begin
        end
      endcase
    end
  end

  clcd_seq u_seq (
    .clk        (clk),
    .rst        (rst),
    .req        (req),
    .phase      (phase),
    .short_hold (short_hold),
    .long_hold  (long_hold),
    .status     (status)
  );

  `CHK_NEXT(a_busy_after_req, clk, rst, req.valid && req.ready && (req.op <= OP_INIT), !req.ready)
  `CHK_ALWAYS(a_last_on_low, clk, rst, !(phase.valid && phase.last && phase.enable))
  `CHK_ALWAYS(a_byte_range, clk, rst, !(status.busy && (status.byte_idx > LAST_INIT_BYTE)))

endmodule

/* rtl/core/clcd_byte_sel.sv */
// Picks the byte, register select and hold class for the current byte slot.
// Depends on clcd_pkg.
`timescale 1ns / 1ps
module clcd_byte_sel import clcd_pkg::*; (
  input  logic [2:0] op,
  input  logic [7:0] value,
  input  logic [7:0] pos,
  input  logic [2:0] idx,
  output byte_info_t info
);

  always_comb begin
    info.rs         = 1'b0;
    info.slow       = 1'b0;
    info.code       = value;
    info.final_byte = 1'b1;
    case (op)
      OP_CMD: begin
      end
      OP_DATA: begin
        info.rs = 1'b1;
      end
      OP_SLOW: begin
        info.slow = 1'b1;
      end
      OP_POS: begin
        info.code = pos;
      end
      OP_INIT: begin
        info.code       = init_byte(idx);
        info.slow       = init_slow(idx);
        info.final_byte = (idx == LAST_INIT_BYTE);
      end
      default: begin
      end
    endcase
  end

endmodule

/* rtl/core/clcd_seq.sv */
// Phase sequencer: walks bytes and nibble phases, drives the output register.
// Depends on clcd_pkg, clcd_if and clcd_byte_sel.
`timescale 1ns / 1ps
module clcd_seq import clcd_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  clcd_req_if.sink           req,
  clcd_phase_if.source       phase,
  input  logic [HoldW-1:0]   short_hold,
  input  logic [HoldW-1:0]   long_hold,
  output seq_status_t        status
);

  state_t           state;
  logic [2:0]       op_q;
  logic [7:0]       value_q;
  logic [7:0]       pos_q;
  logic [7:0]       pos_next;
  logic [2:0]       byte_idx;
  logic [1:0]       ph;
  logic             out_valid;
  logic             load;
  byte_info_t       info;

  clcd_byte_sel u_sel (
    .op    (op_q),
    .value (value_q),
    .pos   (pos_q),
    .idx   (byte_idx),
    .info  (info)
  );

  assign req.ready   = (state == ST_IDLE);
  assign load        = (state == ST_RUN) && (!out_valid || phase.ready);
  assign phase.valid = out_valid;
  assign status.busy     = (state == ST_RUN);
  assign status.byte_idx = byte_idx;

  always_comb begin
    case (req.column)
      2'd1:    pos_next = {LINE1_TAG, req.row};
      2'd2:    pos_next = {LINE2_TAG, req.row};
      default: pos_next = POS_LINE1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
      byte_idx  <= 3'd0;
      ph        <= 2'd0;
    end else begin
      if (req.valid && req.ready && (req.op <= OP_INIT)) begin
        state    <= ST_RUN;
        byte_idx <= 3'd0;
        ph       <= 2'd0;
      end
      if (load) begin
        out_valid <= 1'b1;
        ph        <= ph + 2'd1;
        if (ph == 2'd3) begin
          byte_idx <= byte_idx + 3'd1;
          if (info.final_byte) begin
            state <= ST_IDLE;
          end
        end
      end else if (phase.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // request and phase payload
  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      op_q    <= req.op;
      value_q <= req.value;
      pos_q   <= pos_next;
    end
    if (load) begin
      phase.reg_select <= info.rs;
      phase.enable     <= ~ph[0];
      phase.nibble     <= ph[1] ? info.code[3:0] : info.code[7:4];
      phase.hold_ticks <= info.slow ? long_hold : short_hold;
      phase.last       <= (ph == 2'd3) && info.final_byte;
    end
  end

endmodule
